### hw/rtl/pic_pkg.sv
`default_nettype none

package pic_pkg;

  // Command codes
  localparam logic [2:0] CMD_READ     = 3'd0;
  localparam logic [2:0] CMD_WRITE    = 3'd1;
  localparam logic [2:0] CMD_RAISE    = 3'd2;
  localparam logic [2:0] CMD_DROP     = 3'd3;
  localparam logic [2:0] CMD_DROP_ALL = 3'd4;

  // Bus register offsets
  localparam logic [1:0] REG_PENDING = 2'd0;
  localparam logic [1:0] REG_LEVEL   = 2'd1;
  localparam logic [1:0] REG_MASK    = 2'd2;
  localparam logic [1:0] REG_NONE    = 2'd3;

  localparam logic [7:0] MASK_RESET = 8'hff;

  // Packed so the first field lands in the highest bits.
  typedef struct packed {
    logic [2:0] irq_line;
    logic [7:0] write_data;
    logic [1:0] reg_offset;
    logic [2:0] command;
  } item_t;

  typedef struct packed {
    logic       level_driven;
    logic [2:0] cpu_level;
    logic [7:0] read_data;
  } result_t;

  // Highest set line from 7 down to 1, 0 if none.
  function automatic logic [2:0] top_line(input logic [7:0] bits);
    logic [2:0] lvl;
    lvl = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (bits[i]) begin
        lvl = 3'(i);
      end
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pic_core.sv
`default_nettype none

module pic_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,   // process item this cycle
  input  wire pic_pkg::item_t  item,
  output pic_pkg::result_t     result
);
  import pic_pkg::*;

  logic [7:0] pending_r, pending_nxt;
  logic [7:0] mask_r, mask_nxt;
  logic [2:0] level_r, level_nxt;
  logic [7:0] line_bit;
  logic [7:0] raised;
  logic [7:0] dropped;

  assign line_bit = 8'd1 << item.irq_line;
  assign raised   = (pending_r | line_bit) & mask_r;
  assign dropped  = pending_r & ~line_bit & mask_r;

  always_comb begin
    pending_nxt         = pending_r;
    mask_nxt            = mask_r;
    level_nxt           = level_r;
    result.read_data    = 8'd0;
    result.level_driven = 1'b0;
    unique case (item.command)
      CMD_READ: begin
        unique case (item.reg_offset)
          REG_PENDING: result.read_data = pending_r;
          REG_LEVEL:   result.read_data = {5'd0, level_r};
          REG_MASK:    result.read_data = mask_r;
          REG_NONE:    result.read_data = 8'd0;
          default:     result.read_data = 8'd0;
        endcase
      end
      CMD_WRITE: begin
        if (item.reg_offset == REG_MASK) begin
          mask_nxt = item.write_data;
        end
      end
      CMD_RAISE: begin
        pending_nxt = raised;
        if ((raised != pending_r) && (item.irq_line > level_r)) begin
          level_nxt           = item.irq_line;
          result.level_driven = 1'b1;
        end
      end
      CMD_DROP: begin
        pending_nxt         = dropped;
        level_nxt           = top_line(dropped);
        result.level_driven = 1'b1;
      end
      CMD_DROP_ALL: begin
        pending_nxt         = 8'd0;
        level_nxt           = 3'd0;
        result.level_driven = 1'b1;
      end
      default: ;  // unused codes: no effect
    endcase
    result.cpu_level = level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 8'd0;
      mask_r    <= MASK_RESET;
      level_r   <= 3'd0;
    end else if (step) begin
      pending_r <= pending_nxt;
      mask_r    <= mask_nxt;
      level_r   <= level_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/priority_interrupt_controller.sv
// Eight-line priority interrupt controller on a pair of streams. Each input
// item is one command: a bus read of pending (offset 0), level (offset 1) or
// mask (offset 2, reset 0xff), offset 3 reading as 0; a bus write, which only
// changes the mask at offset 2; raising a line, which sets its pending bit,
// re-masks pending and lifts the level only if pending changed and the line
// is above the current level; dropping a line, which clears it, re-masks and
// sets the level to the highest pending line 7..1 (or 0); and dropping all
// lines. Every item gives exactly one result item with the read byte (zero
// unless a read), the level after the command and a flag telling whether the
// level was driven. An item passes an input register and an output register,
// so its result is presented once the item moves on from the input register
// to the output register; with out_tready held high the block takes and
// returns one item every clock. The pending, mask and level
// registers update in the cycle an item moves from the input register to the
// output register, so the next item already sees its effect.
`default_nettype none

module priority_interrupt_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // command[2:0], reg_offset[4:3],
                                       // write_data[12:5], irq_line[15:13]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // read_data[7:0], cpu_level[10:8],
                                       // level_driven[11], zero[15:12]
);
  import pic_pkg::*;

  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t result_r;
  result_t result_nxt;
  logic    advance;

  // Output slot is free or being emptied: the held item may move forward.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  pic_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_valid_r && advance),
    .item   (item_r),
    .result (result_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_t'(in_tdata);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, result_r};

endmodule

`default_nettype wire

### hw/rtl/pic_checker.sv
`default_nettype none

module pic_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Nothing comes out right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A command that drives the level is never a read.
  a_driven_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> out_tdata[7:0] == 8'd0)
    else $error("read data on a level-driving result");

  // Padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:12] == 4'd0)
    else $error("nonzero padding in result");

  // An item taken into an empty block is checked to show up as a result
  // when the result side is ready throughout.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid && out_tready ##1 out_tready
      |=> out_tvalid)
    else $error("result missing after item");

endmodule

bind priority_interrupt_controller pic_checker u_pic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
